### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the converter RTL
// Implication checks on a rising clock edge, disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define SRA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sra: same-cycle check failed");

// Next-cycle implication
`define SRA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sra: next-cycle check failed");

`endif

### hw/rtl/sra_pkg.sv
// ----------------------------------------------------------------------------
// sra_pkg
// Shared constants, register map, queue status type and the symbol lookup
// for the signed radix-to-ASCII converter.
// ----------------------------------------------------------------------------
`default_nettype none

package sra_pkg;

	// Parameter defaults
	localparam int MAX_DIGITS_DEF  = 32;
	localparam int VALUE_WIDTH_DEF = 32;
	localparam int MAX_RADIX_DEF   = 16;

	// Fixed field widths
	localparam int RADIX_W = 5;
	localparam int CHAR_W  = 8;
	localparam int DIGIT_W = 4;
	localparam int NUM_SYM = 16;
	localparam int SYM_W   = NUM_SYM * CHAR_W;

	// Configuration port
	localparam int APB_DW = 32;
	localparam int APB_AW = 5;
	localparam int REG_IW = APB_AW - 2;

	// Register indexes
	localparam logic [REG_IW-1:0] REG_RADIX     = 3'd0;
	localparam logic [REG_IW-1:0] REG_SYM_0_3   = 3'd1;
	localparam logic [REG_IW-1:0] REG_SYM_4_7   = 3'd2;
	localparam logic [REG_IW-1:0] REG_SYM_8_11  = 3'd3;
	localparam logic [REG_IW-1:0] REG_SYM_12_15 = 3'd4;

	// Register reset values: decimal, "0123456789ABCDEF"
	localparam logic [RADIX_W-1:0] RST_RADIX     = 5'd10;
	localparam logic [APB_DW-1:0]  RST_SYM_0_3   = 32'h3332_3130;
	localparam logic [APB_DW-1:0]  RST_SYM_4_7   = 32'h3736_3534;
	localparam logic [APB_DW-1:0]  RST_SYM_8_11  = 32'h4241_3938;
	localparam logic [APB_DW-1:0]  RST_SYM_12_15 = 32'h4645_4443;

	localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'd45;

	// Status of the descriptor queue between front and back
	typedef struct packed {
		logic full;
		logic empty;
		logic wr_bank;
		logic rd_bank;
	} sra_qstat_t;

	// Pick the character of one digit from the packed alphabet
	function automatic logic [CHAR_W-1:0] symbol_of(input logic [SYM_W-1:0] syms,
			input logic [DIGIT_W-1:0] digit);
		return syms[int'(digit) * CHAR_W +: CHAR_W];
	endfunction

endpackage

`default_nettype wire

### hw/rtl/sra_cfg.sv
// ----------------------------------------------------------------------------
// sra_cfg
// APB register file: radix and the four packed symbol words.
// ----------------------------------------------------------------------------
`default_nettype none

module sra_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sra_pkg::APB_AW-1:0]  paddr,
	input  logic [sra_pkg::APB_DW-1:0]  pwdata,
	output logic [sra_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	output logic [sra_pkg::RADIX_W-1:0] radix,
	output logic [sra_pkg::SYM_W-1:0]   symbols
);
	import sra_pkg::*;

	logic [RADIX_W-1:0]          radix_q;
	logic [NUM_SYM/4-1:0][APB_DW-1:0] sym_q;
	logic [REG_IW-1:0]           reg_idx;
	logic                        wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_AW-1:2];
	assign wr_en   = psel & penable & pwrite;
	assign radix   = radix_q;
	assign symbols = sym_q;

	// Write a register on the access beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q  <= RST_RADIX;
			sym_q[0] <= RST_SYM_0_3;
			sym_q[1] <= RST_SYM_4_7;
			sym_q[2] <= RST_SYM_8_11;
			sym_q[3] <= RST_SYM_12_15;
		end else if (wr_en) begin
			case (reg_idx)
				REG_RADIX:     radix_q  <= pwdata[RADIX_W-1:0];
				REG_SYM_0_3:   sym_q[0] <= pwdata;
				REG_SYM_4_7:   sym_q[1] <= pwdata;
				REG_SYM_8_11:  sym_q[2] <= pwdata;
				REG_SYM_12_15: sym_q[3] <= pwdata;
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (reg_idx)
			REG_RADIX:     prdata = APB_DW'(radix_q);
			REG_SYM_0_3:   prdata = sym_q[0];
			REG_SYM_4_7:   prdata = sym_q[1];
			REG_SYM_8_11:  prdata = sym_q[2];
			REG_SYM_12_15: prdata = sym_q[3];
			default:       prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

### hw/rtl/sra_front.sv
// ----------------------------------------------------------------------------
// sra_front
// Takes a value, forms sign and magnitude and splits the magnitude into
// digits by repeated division, eight quotient bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sra_front #(
	parameter int VALUE_WIDTH = sra_pkg::VALUE_WIDTH_DEF,
	parameter int MAX_DIGITS  = sra_pkg::MAX_DIGITS_DEF,
	parameter int MAX_RADIX   = sra_pkg::MAX_RADIX_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	output logic                                    busy,
	input  logic signed [VALUE_WIDTH-1:0]           value,
	input  logic [sra_pkg::RADIX_W-1:0]             radix,
	input  sra_pkg::sra_qstat_t                     qstat,
	output logic                                    wr_en,
	output logic [$clog2(MAX_DIGITS):0]             wr_addr,
	output logic [sra_pkg::DIGIT_W-1:0]             wr_digit,
	output logic                                    push,
	output logic                                    push_neg,
	output logic [$clog2(MAX_DIGITS+1)-1:0]         push_count
);
	import sra_pkg::*;

	localparam int DIV_BEATS = (VALUE_WIDTH + 7) / 8;
	localparam int DIV_W     = DIV_BEATS * 8;
	localparam int BEAT_W    = (DIV_BEATS > 1) ? $clog2(DIV_BEATS) : 1;
	localparam int DIG_AW    = $clog2(MAX_DIGITS);
	localparam int CNT_W     = $clog2(MAX_DIGITS + 1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DIV  = 1'b1;

	logic                   state_q;
	logic [BEAT_W-1:0]      beat_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [CNT_W-1:0]       cnt_inc;
	logic                   neg_q;
	logic                   bank_q;
	logic [RADIX_W-1:0]     rad_q;
	logic [DIV_W-1:0]       dvd_q;
	logic [DIGIT_W-1:0]     rem_q;

	logic                   accept;
	logic [VALUE_WIDTH-1:0] val_u;
	logic [VALUE_WIDTH-1:0] mag;
	logic [RADIX_W-1:0]     rad_eff;
	logic [7:0]             top_bits;
	logic [7:0]             qbits;
	logic [RADIX_W-1:0]     rem_v;
	logic [DIGIT_W-1:0]     rem_nxt;
	logic [DIV_W-1:0]       dvd_nxt;
	logic                   last_beat;
	logic                   quot_zero;
	logic                   room;

	assign busy   = (state_q == ST_DIV) | qstat.full;
	assign accept = start & ~busy;

	// Magnitude of the input; the most negative value maps to 2^(W-1)
	assign val_u = value;
	assign mag   = val_u[VALUE_WIDTH-1] ? (~val_u + VALUE_WIDTH'(1)) : val_u;

	// Clamp radix into the alphabet
	always_comb begin
		if (radix < RADIX_W'(2))
			rad_eff = RADIX_W'(2);
		else if (radix > RADIX_W'(MAX_RADIX))
			rad_eff = RADIX_W'(MAX_RADIX);
		else
			rad_eff = radix;
	end

	// Eight restoring division steps on the top byte of the dividend
	assign top_bits = dvd_q[DIV_W-1 -: 8];
	always_comb begin
		rem_v = RADIX_W'(rem_q);
		qbits = '0;
		for (int i = 7; i >= 0; i--) begin
			rem_v = {rem_v[DIGIT_W-1:0], top_bits[i]};
			if (rem_v >= rad_q) begin
				rem_v    = rem_v - rad_q;
				qbits[i] = 1'b1;
			end
		end
	end
	assign rem_nxt   = rem_v[DIGIT_W-1:0];
	assign dvd_nxt   = (dvd_q << 8) | DIV_W'(qbits);
	assign last_beat = (beat_q == BEAT_W'(DIV_BEATS - 1));
	assign quot_zero = (dvd_nxt == '0);

	// Keep only the least significant digits once the store is full
	assign room    = (cnt_q < CNT_W'(MAX_DIGITS));
	assign cnt_inc = room ? (cnt_q + CNT_W'(1)) : cnt_q;

	assign wr_en      = (state_q == ST_DIV) & last_beat & room;
	assign wr_addr    = {bank_q, cnt_q[DIG_AW-1:0]};
	assign wr_digit   = rem_nxt;
	assign push       = (state_q == ST_DIV) & last_beat & quot_zero;
	assign push_neg   = neg_q;
	assign push_count = cnt_inc;

	// Sequence the digit passes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			beat_q  <= '0;
			cnt_q   <= '0;
			neg_q   <= 1'b0;
			bank_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DIV;
						beat_q  <= '0;
						cnt_q   <= '0;
						neg_q   <= val_u[VALUE_WIDTH-1];
						bank_q  <= qstat.wr_bank;
					end
				end
				ST_DIV: begin
					if (last_beat) begin
						beat_q <= '0;
						cnt_q  <= cnt_inc;
						if (quot_zero)
							state_q <= ST_IDLE;
					end else begin
						beat_q <= beat_q + BEAT_W'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Dividend, partial remainder and latched radix
	always_ff @(posedge clk) begin
		if (accept) begin
			dvd_q <= DIV_W'(mag);
			rem_q <= '0;
			rad_q <= rad_eff;
		end else if (state_q == ST_DIV) begin
			dvd_q <= dvd_nxt;
			rem_q <= last_beat ? '0 : rem_nxt;
		end
	end

	// The bank being filled keeps its queue slot reserved
	`SRA_ASSERT_IMP(a_front_slot_held, clk, arst_n, state_q == ST_DIV, !qstat.full)

endmodule

`default_nettype wire

### hw/rtl/sra_dq.sv
// ----------------------------------------------------------------------------
// sra_dq
// Two-entry descriptor queue (sign, digit count); each entry owns one bank
// of the digit store.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sra_dq #(
	parameter int MAX_DIGITS = sra_pkg::MAX_DIGITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  logic                            push_neg,
	input  logic [$clog2(MAX_DIGITS+1)-1:0] push_count,
	input  logic                            pop,
	output sra_pkg::sra_qstat_t             qstat,
	output logic                            head_neg,
	output logic [$clog2(MAX_DIGITS+1)-1:0] head_count
);
	import sra_pkg::*;

	localparam int CNT_W = $clog2(MAX_DIGITS + 1);

	logic             ent_neg_q [0:1];
	logic [CNT_W-1:0] ent_cnt_q [0:1];
	logic             wptr_q;
	logic             rptr_q;
	logic [1:0]       occ_q;

	assign qstat.full    = (occ_q == 2'd2);
	assign qstat.empty   = (occ_q == 2'd0);
	assign qstat.wr_bank = wptr_q;
	assign qstat.rd_bank = rptr_q;
	assign head_neg      = ent_neg_q[rptr_q];
	assign head_count    = ent_cnt_q[rptr_q];

	// Store the pushed descriptor
	always_ff @(posedge clk) begin
		if (push) begin
			ent_neg_q[wptr_q] <= push_neg;
			ent_cnt_q[wptr_q] <= push_count;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			occ_q  <= 2'd0;
		end else begin
			if (push)
				wptr_q <= ~wptr_q;
			if (pop)
				rptr_q <= ~rptr_q;
			case ({push, pop})
				2'b10:   occ_q <= occ_q + 2'd1;
				2'b01:   occ_q <= occ_q - 2'd1;
				default: occ_q <= occ_q;
			endcase
		end
	end

	`SRA_ASSERT_IMP(a_dq_no_overflow, clk, arst_n, push, !qstat.full)
	`SRA_ASSERT_IMP(a_dq_no_underflow, clk, arst_n, pop, !qstat.empty)

endmodule

`default_nettype wire

### hw/rtl/sra_back.sv
// ----------------------------------------------------------------------------
// sra_back
// Holds the two-bank digit store and emits the head item's characters:
// a minus sign for a negative item, then the digits most significant first.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sra_back #(
	parameter int MAX_DIGITS = sra_pkg::MAX_DIGITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [$clog2(MAX_DIGITS):0]     wr_addr,
	input  logic [sra_pkg::DIGIT_W-1:0]     wr_digit,
	input  sra_pkg::sra_qstat_t             qstat,
	input  logic                            head_neg,
	input  logic [$clog2(MAX_DIGITS+1)-1:0] head_count,
	output logic                            pop,
	input  logic [sra_pkg::SYM_W-1:0]       symbols,
	output logic                            strobe,
	output logic [sra_pkg::CHAR_W-1:0]      character,
	output logic                            last
);
	import sra_pkg::*;

	localparam int DIG_AW = $clog2(MAX_DIGITS);
	localparam int MEM_D  = 2 << DIG_AW;

	logic [DIGIT_W-1:0] digit_mem_q [0:MEM_D-1];

	logic               active_q;
	logic               neg_pend_q;
	logic [DIG_AW-1:0]  idx_q;
	logic               vld_s1;
	logic               minus_s1;
	logic               last_s1;
	logic [DIGIT_W-1:0] rd_digit_s1;
	logic               strobe_q;
	logic [CHAR_W-1:0]  char_q;
	logic               last_q;

	logic               begin_item;
	logic               rd_en;
	logic               rd_last;

	assign begin_item = ~active_q & ~qstat.empty;
	assign rd_en      = active_q & ~neg_pend_q;
	assign rd_last    = rd_en & (idx_q == '0);
	assign pop        = rd_last;

	// Digit store: one write port from the front, one registered read
	always_ff @(posedge clk) begin
		if (wr_en)
			digit_mem_q[wr_addr] <= wr_digit;
		if (rd_en)
			rd_digit_s1 <= digit_mem_q[{qstat.rd_bank, idx_q}];
	end

	// Walk the head item: minus slot first, then digits downwards
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			neg_pend_q <= 1'b0;
			idx_q      <= '0;
		end else if (begin_item) begin
			active_q   <= 1'b1;
			neg_pend_q <= head_neg;
			idx_q      <= DIG_AW'(head_count - 1'b1);
		end else if (active_q) begin
			if (neg_pend_q)
				neg_pend_q <= 1'b0;
			else if (rd_last)
				active_q <= 1'b0;
			else
				idx_q <= idx_q - DIG_AW'(1);
		end
	end

	// Track the slot alongside the read, then register the beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			minus_s1 <= 1'b0;
			last_s1  <= 1'b0;
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			vld_s1   <= active_q;
			minus_s1 <= active_q & neg_pend_q;
			last_s1  <= rd_last;
			strobe_q <= vld_s1;
			last_q   <= vld_s1 & last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1)
			char_q <= minus_s1 ? MINUS_CHAR : symbol_of(symbols, rd_digit_s1);
	end

	assign strobe    = strobe_q;
	assign character = char_q;
	assign last      = last_q;

	// The head descriptor stays queued until its last digit is read
	`SRA_ASSERT_IMP(a_back_head_held, clk, arst_n, active_q, !qstat.empty)
	// Final characters of two items never fall on back-to-back beats
	`SRA_ASSERT_NXT(a_back_last_spaced, clk, arst_n, strobe_q && last_q, !last_q)

endmodule

`default_nettype wire

### hw/rtl/signed_radix_to_ascii_top.sv
// ----------------------------------------------------------------------------
// signed_radix_to_ascii_top
// Converts a signed integer to its text in a programmable radix (2 to 16)
// through a programmable 16-symbol alphabet; a negative value starts with
// '-', digits follow most significant first, last marks the final character.
// An item is taken when start is high and busy low. The front divides the
// magnitude by the radix eight quotient bits per cycle and takes no new
// item until it has pushed the previous one's descriptor and the
// descriptor queue has a free entry. Finished digits sit in a two-bank
// store; the back emits one character per cycle within an item, and strobe
// drops between items. An item's first character passes the descriptor
// queue, the back's walk state, the store read stage and the output
// register. Each character is shown on character/last for a single cycle
// with strobe high and is not held: the receiver must take it in that
// cycle. Registers may be written only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_radix_to_ascii_top #(
	parameter int MAX_DIGITS  = sra_pkg::MAX_DIGITS_DEF,
	parameter int VALUE_WIDTH = sra_pkg::VALUE_WIDTH_DEF,
	parameter int MAX_RADIX   = sra_pkg::MAX_RADIX_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [VALUE_WIDTH-1:0] value,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sra_pkg::APB_AW-1:0]    paddr,
	input  logic [sra_pkg::APB_DW-1:0]    pwdata,
	output logic [sra_pkg::APB_DW-1:0]    prdata,
	output logic                          pready,
	output logic                          strobe,
	output logic [sra_pkg::CHAR_W-1:0]    character,
	output logic                          last
);
	import sra_pkg::*;

	localparam int DIG_AW = $clog2(MAX_DIGITS);
	localparam int CNT_W  = $clog2(MAX_DIGITS + 1);

	logic [RADIX_W-1:0] radix;
	logic [SYM_W-1:0]   symbols;
	sra_qstat_t         qstat;
	logic               wr_en;
	logic [DIG_AW:0]    wr_addr;
	logic [DIGIT_W-1:0] wr_digit;
	logic               push;
	logic               push_neg;
	logic [CNT_W-1:0]   push_count;
	logic               pop;
	logic               head_neg;
	logic [CNT_W-1:0]   head_count;

	sra_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.radix   (radix),
		.symbols (symbols)
	);

	sra_front #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.MAX_DIGITS  (MAX_DIGITS),
		.MAX_RADIX   (MAX_RADIX)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.value      (value),
		.radix      (radix),
		.qstat      (qstat),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_digit   (wr_digit),
		.push       (push),
		.push_neg   (push_neg),
		.push_count (push_count)
	);

	sra_dq #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_dq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_neg   (push_neg),
		.push_count (push_count),
		.pop        (pop),
		.qstat      (qstat),
		.head_neg   (head_neg),
		.head_count (head_count)
	);

	sra_back #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_digit   (wr_digit),
		.qstat      (qstat),
		.head_neg   (head_neg),
		.head_count (head_count),
		.pop        (pop),
		.symbols    (symbols),
		.strobe     (strobe),
		.character  (character),
		.last       (last)
	);

endmodule

`default_nettype wire
